// ===== rtl/dhsd_pkg.sv =====
// Shared types and constants for the double-hash string dictionary.
package dhsd_pkg;

    localparam int TEXT_W    = 64;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 12;
    localparam int BYTES     = 8;
    localparam int MAX_CHARS = 8;
    localparam int KEY_W     = 25;
    localparam int REM_BITS  = 4;

    localparam logic [7:0] BASE_CHAR = 8'd65;

    localparam logic [KEY_W-1:0] POW5 [0:BYTES-1] = '{
        25'd1, 25'd5, 25'd25, 25'd125, 25'd625, 25'd3125, 25'd15625, 25'd78125
    };

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TERMS,
        S_SUM,
        S_REM,
        S_SETUP,
        S_READ,
        S_CMP,
        S_RESULT
    } dhsd_state_t;

    typedef struct packed {
        logic                clear;
        logic                load;
        logic                terms;
        logic                sum;
        logic                setup;
        logic                read;
        logic                advance;
        logic                write;
        logic                set_result;
        logic [STATUS_W-1:0] code;
        logic                take_slot;
        logic                out_load;
    } dhsd_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic kind;
        logic bad;
        logic empty;
        logic rem_done;
        logic hit;
        logic vacant;
        logic last_probe;
        logic out_free;
    } dhsd_stat_t;

endpackage

// ===== rtl/dhsd_req_if.sv =====
// Request channel: operation kind and packed string.
interface dhsd_req_if import dhsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TEXT_W-1:0] text;

    modport source (output valid, output kind, output text, input ready);
    modport sink   (input valid, input kind, input text, output ready);
endinterface

// ===== rtl/dhsd_rsp_if.sv =====
// Response channel: status code and slot number.
interface dhsd_rsp_if import dhsd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== rtl/dhsd_rem.sv =====
// Multicycle remainder of the key by a constant divisor, several bits per cycle.
module dhsd_rem import dhsd_pkg::*; #(
    parameter int DIVISOR = 4093,
    parameter int DIV_W   = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] dividend,
    output logic             done,
    output logic [DIV_W-1:0] rem
);

    localparam int ITERS = (KEY_W + REM_BITS - 1) / REM_BITS;
    localparam int PAD_W = ITERS * REM_BITS;
    localparam int CNT_W = $clog2(ITERS + 1);
    localparam logic [DIV_W:0] DIV_VAL = (DIV_W + 1)'(DIVISOR);

    logic [PAD_W-1:0] shift_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W:0]   rem_next;

    always_comb
    begin
        rem_next = {1'b0, rem_reg};
        for (int k = 0; k < REM_BITS; k++)
        begin
            rem_next = {rem_next[DIV_W-1:0], shift_reg[PAD_W-1-k]};
            if (rem_next >= DIV_VAL)
            begin
                rem_next = rem_next - DIV_VAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(ITERS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= PAD_W'(dividend);
            rem_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            shift_reg <= shift_reg << REM_BITS;
            rem_reg   <= rem_next[DIV_W-1:0];
        end
    end

    assign done = (cnt_reg == '0);
    assign rem  = rem_reg;

endmodule

// ===== rtl/dhsd_datapath.sv =====
// Datapath: key build, remainder units, probe walk, table memory and result register.
module dhsd_datapath import dhsd_pkg::*; #(
    parameter int TABLE_SIZE = 4093,
    parameter int IDX_W      = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_kind,
    input  logic [TEXT_W-1:0]   in_text,
    input  dhsd_cmd_t           cmd,
    output dhsd_stat_t          stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] out_status,
    output logic [SLOT_W-1:0]   out_slot
);

    logic [TEXT_W-1:0]   text_reg;
    logic                kind_reg;
    logic                bad_reg;
    logic [KEY_W-1:0]    term_reg [0:BYTES-1];
    logic [IDX_W-1:0]    j_reg;
    logic [IDX_W-1:0]    step_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    clr_addr_reg;
    logic [TEXT_W-1:0]   rd_data_reg;
    logic [STATUS_W-1:0] res_code_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [TEXT_W-1:0]   mem [0:TABLE_SIZE-1];

    logic [TEXT_W-1:0] trim_text;
    logic              trim_bad;
    logic [KEY_W-1:0]  key_sum;
    logic [IDX_W-1:0]  rem_home;
    logic [IDX_W-1:0]  rem_hop;
    logic              home_done;
    logic              hop_done;
    logic [IDX_W:0]    j_sum;
    logic [IDX_W-1:0]  j_next;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [TEXT_W-1:0] mem_wd;
    logic              clr_last;

    // Keep bytes up to the first zero byte; flag any kept byte below 'A'.
    always_comb
    begin
        logic alive;
        logic [7:0] b;
        alive     = 1'b1;
        trim_text = '0;
        trim_bad  = 1'b0;
        for (int n = 0; n < BYTES; n++)
        begin
            b     = in_text[8*n +: 8];
            alive = alive && (b != 8'd0) && (n < MAX_CHARS);
            if (alive)
            begin
                trim_text[8*n +: 8] = b;
                if (b < BASE_CHAR)
                begin
                    trim_bad = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        key_sum = '0;
        for (int n = 0; n < BYTES; n++)
        begin
            key_sum = key_sum + term_reg[n];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            text_reg <= trim_text;
            kind_reg <= in_kind;
            bad_reg  <= trim_bad;
        end
        if (cmd.terms)
        begin
            for (int n = 0; n < BYTES; n++)
            begin
                if (text_reg[8*n +: 8] != 8'd0)
                begin
                    term_reg[n] <= KEY_W'(text_reg[8*n +: 8] - BASE_CHAR) * POW5[n];
                end
                else
                begin
                    term_reg[n] <= '0;
                end
            end
        end
    end

    dhsd_rem #(
        .DIVISOR (TABLE_SIZE),
        .DIV_W   (IDX_W)
    ) u_rem_home (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sum),
        .dividend (key_sum),
        .done     (home_done),
        .rem      (rem_home)
    );

    dhsd_rem #(
        .DIVISOR (TABLE_SIZE - 1),
        .DIV_W   (IDX_W)
    ) u_rem_hop (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sum),
        .dividend (key_sum),
        .done     (hop_done),
        .rem      (rem_hop)
    );

    // Advance the probe slot by the step, wrapping around the table.
    always_comb
    begin
        j_sum = {1'b0, j_reg} + {1'b0, step_reg};
        if (j_sum >= (IDX_W + 1)'(TABLE_SIZE))
        begin
            j_sum = j_sum - (IDX_W + 1)'(TABLE_SIZE);
        end
        j_next = j_sum[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            j_reg    <= rem_home;
            step_reg <= rem_hop + 1'b1;
            cnt_reg  <= '0;
        end
        else if (cmd.advance)
        begin
            j_reg   <= j_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign clr_last = (clr_addr_reg == IDX_W'(TABLE_SIZE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear && !clr_last)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign mem_we = cmd.clear || cmd.write;
    assign mem_wa = cmd.clear ? clr_addr_reg : j_reg;
    assign mem_wd = cmd.clear ? '0 : text_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[j_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            res_code_reg <= cmd.code;
            res_slot_reg <= cmd.take_slot ? SLOT_W'(j_reg) : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_code_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.clr_last   = clr_last;
    assign stat.kind       = kind_reg;
    assign stat.bad        = bad_reg;
    assign stat.empty      = (text_reg[7:0] == 8'd0);
    assign stat.rem_done   = home_done && hop_done;
    assign stat.hit        = (rd_data_reg == text_reg);
    assign stat.vacant     = (rd_data_reg == '0);
    assign stat.last_probe = (cnt_reg == IDX_W'(TABLE_SIZE - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

endmodule

// ===== rtl/dhsd_ctrl.sv =====
// Controller: sequences clearing, key build, probing and result transfer.
module dhsd_ctrl import dhsd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dhsd_stat_t stat,
    output dhsd_cmd_t  cmd
);

    dhsd_state_t state_reg;
    dhsd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TERMS;
                end
            end
            S_TERMS:
            begin
                cmd.terms = 1'b1;
                if (stat.bad)
                begin
                    cmd.set_result = 1'b1;
                    cmd.code       = ST_INVALID;
                    state_next     = S_RESULT;
                end
                else if (stat.empty)
                begin
                    // An empty string always counts as present
                    cmd.set_result = 1'b1;
                    cmd.code       = stat.kind ? ST_FOUND : ST_PRESENT;
                    state_next     = S_RESULT;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_REM;
            end
            S_REM:
            begin
                if (stat.rem_done)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.hit)
                begin
                    cmd.set_result = 1'b1;
                    cmd.code       = stat.kind ? ST_FOUND : ST_PRESENT;
                    cmd.take_slot  = stat.kind;
                    state_next     = S_RESULT;
                end
                else if (stat.vacant)
                begin
                    cmd.set_result = 1'b1;
                    cmd.write      = !stat.kind;
                    cmd.code       = stat.kind ? ST_MISSING : ST_INSERTED;
                    cmd.take_slot  = !stat.kind;
                    state_next     = S_RESULT;
                end
                else if (stat.last_probe)
                begin
                    cmd.set_result = 1'b1;
                    cmd.code       = stat.kind ? ST_MISSING : ST_FULL;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_RESULT:
            begin
                // Hold the result until the output register is free
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/double_hash_string_dictionary.sv =====
// Sequence: after a request transfer the string is loaded, its byte terms are registered and
// summed into the two key remainders, then each probe reads and compares one slot; an empty
// string or an invalid byte goes straight to the result. Only one request is in flight at a
// time: the next is taken once the response is loaded into the output register, which waits
// on response backpressure.
// Reset: a clearing pass writes every slot to zero with ready low.
module double_hash_string_dictionary import dhsd_pkg::*; #(
    parameter int TABLE_SIZE = 4093
) (
    input logic        clk,
    input logic        rst_n,
    dhsd_req_if.sink   req,
    dhsd_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    dhsd_cmd_t  cmd;
    dhsd_stat_t stat;

    dhsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dhsd_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_kind    (req.kind),
        .in_text    (req.text),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_status (rsp.status),
        .out_slot   (rsp.slot)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in flight");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_PRESENT || rsp.status == ST_MISSING ||
                       rsp.status == ST_FULL || rsp.status == ST_INVALID))
        |-> (rsp.slot == '0))
        else $error("nonzero slot on a response that names none");

    a_write_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (!stat.kind && stat.vacant && !cmd.clear))
        else $error("table write outside an insert into an empty slot");
`endif

endmodule

// ===== dv/tb_double_hash_string_dictionary.sv =====
// Testbench for the double-hash string dictionary: predictor, scoreboard, stimulus.
`timescale 1ns / 1ps

module tb_double_hash_string_dictionary;
    import dhsd_pkg::*;

    localparam int TABLE_SIZE = 4093;
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;

    // {kind, text}: empty strings, trailing garbage, extremes, invalid bytes,
    // key collisions and the highest slot.
    localparam logic [TEXT_W:0] OPENING [0:23] = '{
        {KIND_LOOKUP, 64'h0},
        {KIND_INSERT, 64'h0},
        {KIND_INSERT, 64'hFFFF_FFFF_FFFF_FF00},
        {KIND_INSERT, 64'h41},
        {KIND_LOOKUP, 64'h41},
        {KIND_INSERT, 64'hFFFF_FFFF_FF00_0041},
        {KIND_LOOKUP, 64'h4242_0000_0000_0041},
        {KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF},
        {KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF},
        {KIND_INSERT, 64'h5A5A_5A5A_5A5A_5A5A},
        {KIND_INSERT, 64'h40},
        {KIND_LOOKUP, 64'h40},
        {KIND_INSERT, 64'h4041_4141_4141_4141},
        {KIND_LOOKUP, 64'h0000_0000_0041_0141},
        {KIND_LOOKUP, 64'h0051_5151},
        {KIND_INSERT, 64'h46},
        {KIND_INSERT, 64'h4241},
        {KIND_LOOKUP, 64'h4241},
        {KIND_LOOKUP, 64'h46},
        {KIND_INSERT, 64'h4B},
        {KIND_INSERT, 64'h4246},
        {KIND_LOOKUP, 64'h4246},
        {KIND_INSERT, 64'hE4_4152},
        {KIND_LOOKUP, 64'hE4_4152}
    };

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } reply_t;

    class dict_scoreboard;
        logic [TEXT_W-1:0] stored_words [TABLE_SIZE];
        reply_t            pending_replies [$];
        int                filled;
        int                errors;
        int                inserts;
        int                lookups;
        int                status_seen [8];

        function new();
            foreach (stored_words[i])
                stored_words[i] = '0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            filled  = 0;
            errors  = 0;
            inserts = 0;
            lookups = 0;
        endfunction

        // Work out the reply to an accepted request and apply it to the table.
        function void note_request(input logic kind, input logic [TEXT_W-1:0] raw);
            logic [TEXT_W-1:0] word;
            logic [7:0]        ch;
            int unsigned       key;
            int unsigned       weight;
            int unsigned       stride;
            int unsigned       probe;
            int unsigned       tries;
            bit                bad;
            bit                done;
            reply_t            want;
            word   = '0;
            key    = 0;
            weight = 1;
            bad    = 1'b0;
            done   = 1'b0;
            // The string ends at the first zero byte.
            for (int n = 0; n < MAX_CHARS; n++)
            begin
                ch = raw[8*n +: 8];
                if (ch == 8'd0)
                    break;
                word[8*n +: 8] = ch;
                if (ch < BASE_CHAR)
                    bad = 1'b1;
                else
                    key += weight * (ch - BASE_CHAR);
                weight *= 5;
            end
            if (kind == KIND_INSERT)
                inserts++;
            else
                lookups++;
            want.slot = '0;
            if (bad)
                want.status = ST_INVALID;
            else if (word == '0)
                want.status = (kind == KIND_INSERT) ? ST_PRESENT : ST_FOUND;
            else
            begin
                want.status = (kind == KIND_INSERT) ? ST_FULL : ST_MISSING;
                probe  = key % TABLE_SIZE;
                stride = (1 + key % (TABLE_SIZE - 1)) % TABLE_SIZE;
                for (tries = 0; tries < TABLE_SIZE && !done; tries++)
                begin
                    if (stored_words[probe] == word)
                    begin
                        if (kind == KIND_INSERT)
                            want.status = ST_PRESENT;
                        else
                        begin
                            want.status = ST_FOUND;
                            want.slot   = probe[SLOT_W-1:0];
                        end
                        done = 1'b1;
                    end
                    else if (stored_words[probe] == '0)
                    begin
                        if (kind == KIND_INSERT)
                        begin
                            stored_words[probe] = word;
                            filled++;
                            want.status = ST_INSERTED;
                            want.slot   = probe[SLOT_W-1:0];
                        end
                        else
                            want.status = ST_MISSING;
                        done = 1'b1;
                    end
                    else
                        probe = (probe + stride) % TABLE_SIZE;
                end
            end
            pending_replies.push_back(want);
        endfunction

        function void check_response(input logic [STATUS_W-1:0] status,
                                     input logic [SLOT_W-1:0] slot);
            reply_t want;
            status_seen[status]++;
            if (pending_replies.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR %0t: unexpected response status=%0d slot=%0d",
                             $realtime, status, slot);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status || slot !== want.slot)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("ERROR %0t: status exp %0d got %0d, slot exp %0d got %0d",
                                 $realtime, want.status, status, want.slot, slot);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dhsd_req_if req_ch ();
    dhsd_rsp_if rsp_ch ();

    double_hash_string_dictionary #(.TABLE_SIZE(TABLE_SIZE)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dict_scoreboard board = new();
    logic [TEXT_W-1:0] known_words [$];
    bit hold_rsp;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb_double_hash_string_dictionary failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // Random string of min_len..8 bytes, sometimes with garbage after the terminator.
    function automatic logic [TEXT_W-1:0] make_word(input int min_len);
        logic [TEXT_W-1:0] w;
        int len;
        int span;
        w    = '0;
        len  = $urandom_range(min_len, MAX_CHARS);
        span = $urandom_range(0, 9);
        for (int n = 0; n < len; n++)
        begin
            if (span < 5)
                w[8*n +: 8] = BASE_CHAR + 8'($urandom_range(0, 4));
            else if (span < 9)
                w[8*n +: 8] = BASE_CHAR + 8'($urandom_range(0, 25));
            else
                w[8*n +: 8] = BASE_CHAR + 8'($urandom_range(0, 190));
        end
        if (len < MAX_CHARS && $urandom_range(0, 3) == 0)
            for (int n = len + 1; n < MAX_CHARS; n++)
                w[8*n +: 8] = 8'($urandom);
        return w;
    endfunction

    // Hold the request until the block takes it, then log the transfer.
    task automatic send(input logic kind, input logic [TEXT_W-1:0] text);
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.text  <= text;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_request(kind, text);
        if (kind == KIND_INSERT && text[7:0] >= BASE_CHAR)
            known_words.push_back(text);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic send_noise();
        logic [TEXT_W-1:0] w;
        int variant;
        variant = $urandom_range(0, 2);
        if (variant == 0)
            w = {$urandom, $urandom};
        else if (variant == 1)
        begin
            // Drop one byte below 'A' somewhere in a full-length string.
            w = make_word(MAX_CHARS);
            w[8*$urandom_range(0, MAX_CHARS - 1) +: 8] = 8'($urandom_range(1, 64));
        end
        else
            w = {$urandom, $urandom} << (8 * $urandom_range(1, MAX_CHARS));
        send(1'($urandom_range(0, 1)), w);
    endtask

    function automatic logic [TEXT_W-1:0] pick_known();
        if (known_words.size() == 0)
            return make_word(1);
        return known_words[$urandom_range(0, known_words.size() - 1)];
    endfunction

    // Response side: random stalls, bursts with none, and long hold-offs on request.
    initial
    begin
        int gap;
        int beat;
        rsp_ch.ready <= 1'b0;
        beat = 0;
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                gap = ((beat / 300) % 3 == 2) ? 0 : pick_gap();
                if (gap > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
                beat++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_response(rsp_ch.status, rsp_ch.slot);
    end

    initial
    begin
        int r;
        bit burst;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_INSERT;
        req_ch.text  <= '0;
        hold_rsp      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING[i])
        begin
            send(OPENING[i][TEXT_W], OPENING[i][TEXT_W-1:0]);
            pause_sender(pick_gap());
        end

        // Stall the response side while requests keep coming.
        hold_rsp = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            burst = ((i / 150) % 4 == 3);
            r = $urandom_range(0, 99);
            if (r < 40)
                send(KIND_INSERT, make_word(1));
            else if (r < 70)
                send(KIND_LOOKUP, pick_known());
            else if (r < 80)
                send(KIND_INSERT, pick_known());
            else if (r < 88)
                send(KIND_LOOKUP, make_word(1));
            else
                send_noise();
            pause_sender(burst ? 0 : pick_gap());
        end

        // Stall the response side once more and close with a mixed tail.
        hold_rsp = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            r = $urandom_range(0, 5);
            if (r < 2)
                send(KIND_INSERT, make_word(4));
            else if (r < 4)
                send(KIND_LOOKUP, make_word(4));
            else if (r == 4)
                send(1'($urandom_range(0, 1)), pick_known());
            else
                send_noise();
            pause_sender(pick_gap());
        end
        send(KIND_LOOKUP, 64'h0);
        pause_sender(1);

        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("covered %0d inserts and %0d lookups; table filled to %0d of %0d slots",
                 board.inserts, board.lookups, board.filled, TABLE_SIZE);
        $display("replies: inserted %0d, present %0d, found %0d, missing %0d, full %0d, invalid %0d",
                 board.status_seen[ST_INSERTED], board.status_seen[ST_PRESENT],
                 board.status_seen[ST_FOUND], board.status_seen[ST_MISSING],
                 board.status_seen[ST_FULL], board.status_seen[ST_INVALID]);
        if (board.errors == 0)
            $display("tb_double_hash_string_dictionary passed");
        else
            $display("tb_double_hash_string_dictionary failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dhsd_pkg.sv
rtl/dhsd_req_if.sv
rtl/dhsd_rsp_if.sv
rtl/dhsd_rem.sv
rtl/dhsd_datapath.sv
rtl/dhsd_ctrl.sv
rtl/double_hash_string_dictionary.sv
dv/tb_double_hash_string_dictionary.sv
